/* rtl/ofe_pkg.sv */
// Package for the mono OLED framebuffer engine.
// Holds store geometry, stream command codes, request kinds and address/mask helpers.
// No dependencies.
package ofe_pkg;

  localparam int COLUMNS      = 128;
  localparam int PAGES        = 8;
  localparam int HEADER_BYTES = 3;

  localparam int DEPTH  = COLUMNS * PAGES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int POS_W  = $clog2(COLUMNS + HEADER_BYTES);

  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

  typedef enum logic [1:0] {
    REQ_POINT   = 2'd0,
    REQ_RECT    = 2'd1,
    REQ_CLEAR   = 2'd2,
    REQ_REFRESH = 2'd3
  } req_kind_t;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [ADDR_W-1:0] col,
                                                input logic [PAGE_W-1:0] page);
    addr_of = col * ADDR_W'(PAGES) + ADDR_W'(page);
  endfunction

  function automatic logic [PAGE_W-1:0] page_of(input logic [2:0] grp);
    page_of = PAGE_W'(PAGES - 1) - PAGE_W'(grp);
  endfunction

  function automatic logic [7:0] row_mask(input logic [2:0] grp,
                                          input logic [5:0] ylo,
                                          input logic [5:0] yhi);
    logic [7:0] m;
    logic [5:0] row;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      row = {grp, 3'(b)};
      m[7-b] = (row >= ylo) && (row < yhi);
    end
    row_mask = m;
  endfunction

endpackage

/* rtl/ofe_if.sv */
// Valid/ready channel interfaces for request and result items.
// Depends on ofe_pkg.
interface ofe_req_if import ofe_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [6:0] x_lo;
  logic [6:0] x_hi;
  logic [5:0] y_lo;
  logic [5:0] y_hi;
  logic       pixel_on;

  modport source (output valid, req_type, x_lo, x_hi, y_lo, y_hi, pixel_on, input ready);
  modport sink   (input valid, req_type, x_lo, x_hi, y_lo, y_hi, pixel_on, output ready);
endinterface

interface ofe_res_if import ofe_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_data;
  logic       frame_done;

  modport source (output valid, out_byte, is_data, frame_done, input ready);
  modport sink   (input valid, out_byte, is_data, frame_done, output ready);
endinterface

/* rtl/mono_oled_framebuffer_engine_core.sv */
// Mono OLED framebuffer engine: page-organised pixel store and display stream generator.
// Depends on ofe_pkg and the channel interfaces in ofe_if.sv.
// A refresh result is staged in rf_pend, with its store byte read into rd_data, and then moves
// into the output register once the output is free; a stalled output keeps it staged.
// A new request is taken only when idle, with no store write-back pending and no staged refresh
// result; points and rectangles read-modify-write the pixel memory, and a clear reruns the clearing pass.
// Reset: a clearing pass over all DEPTH (1024) store bytes zeroes the store; no request is taken until it ends.
module mono_oled_framebuffer_engine_core import ofe_pkg::*; (
  input  logic clk,
  input  logic rst,
  ofe_req_if.sink   req,
  ofe_res_if.source res
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RECT,
    ST_CLEAR
  } state_t;

  state_t state;

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data;

  logic              re;
  logic [ADDR_W-1:0] ra;
  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [7:0]        wd;

  logic [ADDR_W-1:0] clr_addr;

  logic              wr_pend;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_mask;
  logic              wr_on;

  logic [6:0] cx;
  logic [7:0] rx_end;
  logic [2:0] cg;
  logic [2:0] rg_lo;
  logic [2:0] rg_hi;
  logic [5:0] ry_lo;
  logic [5:0] ry_hi;
  logic       ron;

  logic [PAGE_W-1:0] refresh_page;
  logic [POS_W-1:0]  refresh_position;

  logic       rf_pend;
  logic       rf_is_data;
  logic [7:0] rf_cmd;
  logic       rf_done;

  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_is_data;
  logic       out_done;

  logic       accept;
  req_kind_t  kind;
  logic       point_ok;
  logic [7:0] x_end;
  logic [5:0] y_last;
  logic [2:0] g_lo;
  logic [2:0] g_hi;
  logic       rect_ok;
  logic [COL_W-1:0] rf_col;
  logic       rf_data_slot;
  logic       out_free;

  assign kind      = req_kind_t'(req.req_type);
  assign req.ready = (state == ST_IDLE) && !wr_pend && !rf_pend;
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || res.ready;

  assign point_ok = (32'(req.x_lo) < COLUMNS) && (32'(req.y_lo[5:3]) < PAGES);

  assign x_end  = (32'(req.x_hi) > COLUMNS) ? 8'(COLUMNS) : {1'b0, req.x_hi};
  assign y_last = req.y_hi - 6'd1;
  assign g_lo   = req.y_lo[5:3];
  assign g_hi   = (32'(y_last[5:3]) >= PAGES) ? 3'(PAGES - 1) : y_last[5:3];
  assign rect_ok = (x_end > {1'b0, req.x_lo}) && (req.y_hi > req.y_lo) &&
                   (32'(g_lo) < PAGES);

  assign rf_data_slot = refresh_position >= POS_W'(HEADER_BYTES);
  assign rf_col       = COL_W'(refresh_position - POS_W'(HEADER_BYTES));

  always_comb begin
    re = 1'b0;
    ra = '0;
    if (state == ST_RECT) begin
      re = 1'b1;
      ra = addr_of(ADDR_W'(cx), page_of(cg));
    end else if (accept && kind == REQ_POINT && point_ok) begin
      re = 1'b1;
      ra = addr_of(ADDR_W'(req.x_lo), page_of(req.y_lo[5:3]));
    end else if (accept && kind == REQ_REFRESH && rf_data_slot) begin
      re = 1'b1;
      ra = addr_of(ADDR_W'(rf_col), refresh_page);
    end
  end

  always_comb begin
    we = 1'b0;
    wa = wr_addr;
    wd = wr_on ? (rd_data | wr_mask) : (rd_data & ~wr_mask);
    if (state == ST_CLEAR) begin
      we = 1'b1;
      wa = clr_addr;
      wd = '0;
    end else if (wr_pend) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_CLEAR;
      clr_addr         <= '0;
      wr_pend          <= 1'b0;
      rf_pend          <= 1'b0;
      out_valid        <= 1'b0;
      refresh_page     <= '0;
      refresh_position <= '0;
    end else begin
      wr_pend <= 1'b0;

      if (out_free) begin
        out_valid <= rf_pend;
        if (rf_pend) begin
          out_byte    <= rf_is_data ? rd_data : rf_cmd;
          out_is_data <= rf_is_data;
          out_done    <= rf_done;
          rf_pend     <= 1'b0;
        end
      end

      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (32'(clr_addr) == DEPTH - 1) begin
            clr_addr <= '0;
            state    <= ST_IDLE;
          end
        end
        ST_RECT: begin
          wr_pend <= 1'b1;
          wr_addr <= ra;
          wr_mask <= row_mask(cg, ry_lo, ry_hi);
          wr_on   <= ron;
          if (cg == rg_hi) begin
            cg <= rg_lo;
            cx <= cx + 7'd1;
            if ({1'b0, cx} + 8'd1 == rx_end) begin
              state <= ST_IDLE;
            end
          end else begin
            cg <= cg + 3'd1;
          end
        end
        default: begin
          if (accept) begin
            case (kind)
              REQ_POINT: begin
                wr_pend <= point_ok;
                wr_addr <= ra;
                wr_mask <= 8'h80 >> req.y_lo[2:0];
                wr_on   <= req.pixel_on;
              end
              REQ_RECT: begin
                cx     <= req.x_lo;
                rx_end <= x_end;
                cg     <= g_lo;
                rg_lo  <= g_lo;
                rg_hi  <= g_hi;
                ry_lo  <= req.y_lo;
                ry_hi  <= req.y_hi;
                ron    <= req.pixel_on;
                if (rect_ok) begin
                  state <= ST_RECT;
                end
              end
              REQ_CLEAR: begin
                state <= ST_CLEAR;
              end
              default: begin
                rf_pend    <= 1'b1;
                rf_is_data <= rf_data_slot;
                rf_done    <= rf_data_slot && (32'(rf_col) == COLUMNS - 1) &&
                              (32'(refresh_page) == PAGES - 1);
                case (refresh_position)
                  POS_W'(0): rf_cmd <= CMD_PAGE_BASE + 8'(refresh_page);
                  POS_W'(1): rf_cmd <= CMD_COL_LOW;
                  default:   rf_cmd <= CMD_COL_HIGH;
                endcase
                if (32'(refresh_position) == COLUMNS + HEADER_BYTES - 1) begin
                  refresh_position <= '0;
                  if (32'(refresh_page) == PAGES - 1) begin
                    refresh_page <= '0;
                  end else begin
                    refresh_page <= refresh_page + PAGE_W'(1);
                  end
                end else begin
                  refresh_position <= refresh_position + POS_W'(1);
                end
              end
            endcase
          end
        end
      endcase
    end
  end

  assign res.valid      = out_valid;
  assign res.out_byte   = out_byte;
  assign res.is_data    = out_is_data;
  assign res.frame_done = out_done;

  a_rf_hold: assert property (@(posedge clk) disable iff (rst)
    rf_pend && out_valid && !res.ready |=> rf_pend)
    else $error("staged refresh result dropped while output stalled");

  a_clear_no_rmw: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !wr_pend && !re)
    else $error("store access overlaps clearing pass");

  a_refresh_staged: assert property (@(posedge clk) disable iff (rst)
    accept && kind == REQ_REFRESH |=> rf_pend)
    else $error("refresh request produced no staged result");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    32'(refresh_position) < COLUMNS + HEADER_BYTES)
    else $error("refresh position out of range");

  a_clr_idle: assert property (@(posedge clk) disable iff (rst)
    state != ST_CLEAR |-> clr_addr == '0)
    else $error("clear counter not parked");

endmodule

/* dv/tb_mono_oled_framebuffer_engine_core.sv */
// Testbench for the mono OLED framebuffer engine: a directed script, then random drawing, clear and refresh requests.
// Every refresh byte is checked against a scripted value or a local model of the pixel store and stream counters.
// Depends on ofe_pkg, ofe_if.sv and mono_oled_framebuffer_engine_core.
`timescale 1ns / 100ps

module tb_mono_oled_framebuffer_engine_core;
  import ofe_pkg::*;

  typedef struct packed {
    req_kind_t  kind;
    logic [6:0] x_lo;
    logic [6:0] x_hi;
    logic [5:0] y_lo;
    logic [5:0] y_hi;
    logic       on;
  } draw_req_t;

  typedef struct packed {
    logic [7:0] value;
    logic       is_data;
    logic       frame_done;
  } stream_byte_t;

  typedef struct packed {
    draw_req_t    rq;
    logic         known;
    stream_byte_t want;
  } script_row_t;

  localparam int SCRIPT_LEN = 24;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{'{REQ_REFRESH, 7'd0,   7'd0,   6'd0,  6'd0,  1'b0}, 1'b1, '{8'hB0, 1'b0, 1'b0}},
    '{'{REQ_REFRESH, 7'd0,   7'd0,   6'd0,  6'd0,  1'b0}, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{'{REQ_REFRESH, 7'd0,   7'd0,   6'd0,  6'd0,  1'b0}, 1'b1, '{8'h10, 1'b0, 1'b0}},
    '{'{REQ_REFRESH, 7'd127, 7'd127, 6'd63, 6'd63, 1'b1}, 1'b1, '{8'h00, 1'b1, 1'b0}},
    '{'{REQ_POINT,   7'd1,   7'd0,   6'd63, 6'd0,  1'b1}, 1'b0, '0},
    '{'{REQ_REFRESH, 7'd0,   7'd0,   6'd0,  6'd0,  1'b0}, 1'b1, '{8'h01, 1'b1, 1'b0}},
    '{'{REQ_POINT,   7'd127, 7'd0,   6'd0,  6'd0,  1'b1}, 1'b0, '0},
    '{'{REQ_POINT,   7'd2,   7'd0,   6'd56, 6'd0,  1'b1}, 1'b0, '0},
    '{'{REQ_RECT,    7'd2,   7'd4,   6'd57, 6'd63, 1'b1}, 1'b0, '0},
    '{'{REQ_REFRESH, 7'd0,   7'd0,   6'd0,  6'd0,  1'b0}, 1'b0, '0},
    '{'{REQ_POINT,   7'd3,   7'd0,   6'd60, 6'd0,  1'b0}, 1'b0, '0},
    '{'{REQ_REFRESH, 7'd0,   7'd0,   6'd0,  6'd0,  1'b0}, 1'b0, '0},
    '{'{REQ_RECT,    7'd10,  7'd10,  6'd0,  6'd63, 1'b1}, 1'b0, '0},
    '{'{REQ_RECT,    7'd20,  7'd4,   6'd60, 6'd59, 1'b1}, 1'b0, '0},
    '{'{REQ_REFRESH, 7'd0,   7'd0,   6'd0,  6'd0,  1'b0}, 1'b1, '{8'h00, 1'b1, 1'b0}},
    '{'{REQ_RECT,    7'd0,   7'd127, 6'd0,  6'd63, 1'b1}, 1'b0, '0},
    '{'{REQ_REFRESH, 7'd0,   7'd0,   6'd0,  6'd0,  1'b0}, 1'b1, '{8'hFE, 1'b1, 1'b0}},
    '{'{REQ_RECT,    7'd0,   7'd127, 6'd0,  6'd63, 1'b0}, 1'b0, '0},
    '{'{REQ_REFRESH, 7'd0,   7'd0,   6'd0,  6'd0,  1'b0}, 1'b1, '{8'h00, 1'b1, 1'b0}},
    '{'{REQ_POINT,   7'd7,   7'd0,   6'd63, 6'd0,  1'b1}, 1'b0, '0},
    '{'{REQ_CLEAR,   7'd127, 7'd127, 6'd63, 6'd63, 1'b1}, 1'b0, '0},
    '{'{REQ_REFRESH, 7'd0,   7'd0,   6'd0,  6'd0,  1'b0}, 1'b1, '{8'h00, 1'b1, 1'b0}},
    '{'{REQ_POINT,   7'd127, 7'd0,   6'd63, 6'd0,  1'b1}, 1'b0, '0},
    '{'{REQ_POINT,   7'd126, 7'd0,   6'd0,  6'd0,  1'b1}, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst;

  ofe_req_if req_ch ();
  ofe_res_if res_ch ();

  mono_oled_framebuffer_engine_core u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  always #5 clk = ~clk;

  logic [7:0]   pixels [DEPTH];
  int unsigned  scan_page;
  int unsigned  scan_pos;
  stream_byte_t stream_due [$];
  int unsigned  src_gap;
  int unsigned  sink_gap;
  int unsigned  faults;

  function automatic void plot(input int unsigned x, input int unsigned y, input logic on);
    int unsigned pg;
    logic [7:0]  m;
    if (x >= COLUMNS || y / 8 >= PAGES) return;
    pg = PAGES - 1 - y / 8;
    m  = 8'h80 >> (y % 8);
    if (on) pixels[x * PAGES + pg] = pixels[x * PAGES + pg] | m;
    else    pixels[x * PAGES + pg] = pixels[x * PAGES + pg] & ~m;
  endfunction

  function automatic logic apply_request(input draw_req_t rq, output stream_byte_t sb);
    int unsigned col;
    sb = '0;
    apply_request = 1'b0;
    case (rq.kind)
      REQ_POINT: plot(rq.x_lo, rq.y_lo, rq.on);
      REQ_RECT: begin
        for (int x = rq.x_lo; x < rq.x_hi; x++)
          for (int y = rq.y_lo; y < rq.y_hi; y++)
            plot(x, y, rq.on);
      end
      REQ_CLEAR: foreach (pixels[i]) pixels[i] = '0;
      default: begin
        if (scan_pos == 0) begin
          sb.value = CMD_PAGE_BASE + 8'(scan_page);
        end else if (scan_pos == 1) begin
          sb.value = CMD_COL_LOW;
        end else if (scan_pos == 2) begin
          sb.value = CMD_COL_HIGH;
        end else begin
          col           = scan_pos - HEADER_BYTES;
          sb.value      = pixels[col * PAGES + scan_page];
          sb.is_data    = 1'b1;
          sb.frame_done = (col == COLUMNS - 1) && (scan_page == PAGES - 1);
        end
        scan_pos++;
        if (scan_pos >= HEADER_BYTES + COLUMNS) begin
          scan_pos  = 0;
          scan_page = (scan_page + 1) % PAGES;
        end
        apply_request = 1'b1;
      end
    endcase
  endfunction

  function automatic draw_req_t random_request(input int unsigned pick);
    draw_req_t rq;
    int unsigned shape;
    rq.x_lo = 7'($urandom_range(127));
    rq.x_hi = 7'($urandom_range(127));
    rq.y_lo = 6'($urandom_range(63));
    rq.y_hi = 6'($urandom_range(63));
    rq.on   = 1'($urandom_range(1));
    if (pick < 45) begin
      rq.kind = REQ_REFRESH;
    end else if (pick < 80) begin
      rq.kind = REQ_POINT;
    end else if (pick < 95) begin
      rq.kind = REQ_RECT;
      shape   = $urandom_range(7);
      if (shape == 0) begin
        rq.x_lo = 7'($urandom_range(20));
        rq.x_hi = 7'($urandom_range(127, 100));
        rq.y_lo = 6'($urandom_range(10));
        rq.y_hi = 6'($urandom_range(63, 50));
      end else if (shape != 1) begin
        rq.x_lo = 7'($urandom_range(126));
        rq.x_hi = (rq.x_lo + 8 > 127) ? 7'd127 : 7'(rq.x_lo + $urandom_range(8, 1));
        rq.y_lo = 6'($urandom_range(62));
        rq.y_hi = (rq.y_lo + 16 > 63) ? 6'd63 : 6'(rq.y_lo + $urandom_range(16, 1));
      end
    end else begin
      rq.kind = REQ_CLEAR;
    end
    return rq;
  endfunction

  task automatic push_request(input draw_req_t rq, input logic known, input stream_byte_t want);
    stream_byte_t sb;
    if (src_gap != 0 && $urandom_range(99) < src_gap) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_gap);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= rq.kind;
    req_ch.x_lo     <= rq.x_lo;
    req_ch.x_hi     <= rq.x_hi;
    req_ch.y_lo     <= rq.y_lo;
    req_ch.y_hi     <= rq.y_hi;
    req_ch.pixel_on <= rq.on;
    do @(posedge clk); while (!req_ch.ready);
    if (apply_request(rq, sb)) begin
      stream_due.push_back(known ? want : sb);
    end
  endtask

  always @(posedge clk) begin
    stream_byte_t got;
    stream_byte_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got = '{res_ch.out_byte, res_ch.is_data, res_ch.frame_done};
        if (stream_due.size() == 0) begin
          $display("%0t: unexpected stream byte %02h is_data %0b frame_done %0b",
                   $time, got.value, got.is_data, got.frame_done);
          faults++;
        end else begin
          want = stream_due.pop_front();
          if (got.value !== want.value || got.is_data !== want.is_data ||
              got.frame_done !== want.frame_done) begin
            $display("%0t: expected %02h is_data %0b frame_done %0b, got %02h is_data %0b frame_done %0b",
                     $time, want.value, want.is_data, want.frame_done,
                     got.value, got.is_data, got.frame_done);
            faults++;
          end
        end
      end
      res_ch.ready <= (sink_gap == 0) || ($urandom_range(99) >= sink_gap);
    end
  end

  initial begin
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_POINT;
    req_ch.x_lo     = '0;
    req_ch.x_hi     = '0;
    req_ch.y_lo     = '0;
    req_ch.y_hi     = '0;
    req_ch.pixel_on = 1'b0;
    foreach (pixels[i]) pixels[i] = '0;
    scan_page = 0;
    scan_pos  = 0;
    faults    = 0;
    src_gap   = 29;
    sink_gap  = 51;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (SCRIPT[i]) push_request(SCRIPT[i].rq, SCRIPT[i].known, SCRIPT[i].want);

    for (int ph = 0; ph < 3; ph++) begin
      src_gap  = (ph == 0) ? 29 : (ph == 1) ? 51 : 0;
      sink_gap = (ph == 0) ? 51 : (ph == 1) ? 29 : 0;
      repeat (142) push_request(random_request($urandom_range(99)), 1'b0, '0);
    end

    req_ch.valid <= 1'b0;
    while (stream_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (faults == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
